// ===== hw/rtl/gbs_pkg.sv =====
// Shared constants, payload types and status types of the greedy box suppression unit.
package gbs_pkg;

    // Store and counter sizing
    localparam int MAX_KEPT  = 64;
    localparam int MAX_ITEMS = 8192;
    localparam int KEPT_AW   = $clog2(MAX_KEPT);
    localparam int CNT_W     = $clog2(MAX_KEPT + 1);
    localparam int IDX_W     = $clog2(MAX_ITEMS);

    // Field and datapath widths
    localparam int COORD_W = 16;
    localparam int SIZE_W  = 15;
    localparam int AREA_W  = 2 * SIZE_W;
    localparam int UNI_W   = AREA_W + 1;
    localparam int THR_W   = 9;
    localparam int PROD_W  = THR_W + UNI_W;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_IOU_THR = '0;
    localparam logic [THR_W-1:0]   THR_RESET   = 9'd115;

    // One box as held in the kept store
    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic        [SIZE_W-1:0]  wide;
        logic        [SIZE_W-1:0]  tall;
    } gbs_box_t;

    // Input beat
    typedef struct packed {
        logic signed [15:0] box_x0;
        logic signed [15:0] box_y0;
        logic        [14:0] box_width;
        logic        [14:0] box_height;
        logic               set_start;
    } gbs_in_t;

    // Result beat
    typedef struct packed {
        logic        keep;
        logic [12:0] item_index;
        logic [6:0]  kept_total;
        logic        store_overflow;
    } gbs_out_t;

    // Status from the IoU pipeline to the sequencer
    typedef struct packed {
        logic busy;
        logic hit;
    } gbs_iou_stat_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_AREA   = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_DECIDE = 5'b01000,
        ST_OUT    = 5'b10000
    } gbs_state_t;

endpackage

// ===== hw/rtl/gbs_kept_store.sv =====
// Kept-box memory: one write port, one registered read port.
module gbs_kept_store
    import gbs_pkg::*;
(
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [KEPT_AW-1:0] wr_addr,
    input  gbs_box_t           wr_data,
    input  logic               rd_en,
    input  logic [KEPT_AW-1:0] rd_addr,
    output gbs_box_t           rd_data
);

    gbs_box_t mem [MAX_KEPT];
    gbs_box_t rd_data_reg;

    // Write a newly kept box
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one entry per cycle during the scan
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/gbs_iou_unit.sv =====
// Pipelined IoU test: one kept box enters per cycle; the suppress hit leaves from a register.
module gbs_iou_unit
    import gbs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  gbs_box_t          kept_box,
    input  gbs_box_t          cand_box,
    input  logic [AREA_W-1:0] cand_area,
    input  logic [THR_W-1:0]  iou_thr,
    output gbs_iou_stat_t     stat
);

    // Overlap length of two 1-D spans, zero when they do not meet
    function automatic logic [SIZE_W-1:0] overlap(
        input logic signed [COORD_W-1:0] a0,
        input logic        [SIZE_W-1:0]  aw,
        input logic signed [COORD_W-1:0] b0,
        input logic        [SIZE_W-1:0]  bw
    );
        logic signed [COORD_W+1:0] a1;
        logic signed [COORD_W+1:0] b1;
        logic signed [COORD_W+1:0] lo;
        logic signed [COORD_W+1:0] hi;
        logic signed [COORD_W+1:0] d;
        a1 = {{2{a0[COORD_W-1]}}, a0} + $signed({3'b000, aw});
        b1 = {{2{b0[COORD_W-1]}}, b0} + $signed({3'b000, bw});
        lo = (a0 > b0) ? {{2{a0[COORD_W-1]}}, a0} : {{2{b0[COORD_W-1]}}, b0};
        hi = (a1 < b1) ? a1 : b1;
        d  = hi - lo;
        return (hi > lo) ? d[SIZE_W-1:0] : '0;
    endfunction

    logic                v1_reg, v2_reg, v3_reg, v4_reg, hit_reg;
    logic [SIZE_W-1:0]   iw_reg, ih_reg;
    logic [AREA_W-1:0]   area_b1_reg, area_b2_reg, inter2_reg;
    logic [AREA_W-1:0]   inter3_reg, inter4_reg;
    logic [UNI_W-1:0]    uni3_reg;
    logic [PROD_W-1:0]   prod4_reg;
    logic                uni_nz4_reg;
    logic [PROD_W-1:0]   inter_scaled;

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            hit_reg <= 1'b0;
        end else begin
            v1_reg  <= in_valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            hit_reg <= v4_reg && uni_nz4_reg && (inter_scaled > prod4_reg);
        end
    end

    assign inter_scaled = {{(PROD_W-AREA_W-8){1'b0}}, inter4_reg, 8'd0};

    // Datapath: overlaps and kept area, intersection, union, scaled union
    always_ff @(posedge aclk) begin
        iw_reg      <= overlap(cand_box.left, cand_box.wide, kept_box.left, kept_box.wide);
        ih_reg      <= overlap(cand_box.top, cand_box.tall, kept_box.top, kept_box.tall);
        area_b1_reg <= AREA_W'(kept_box.wide) * AREA_W'(kept_box.tall);

        inter2_reg  <= AREA_W'(iw_reg) * AREA_W'(ih_reg);
        area_b2_reg <= area_b1_reg;

        uni3_reg    <= {1'b0, cand_area} + {1'b0, area_b2_reg} - {1'b0, inter2_reg};
        inter3_reg  <= inter2_reg;

        prod4_reg   <= PROD_W'(iou_thr) * PROD_W'(uni3_reg);
        inter4_reg  <= inter3_reg;
        uni_nz4_reg <= (uni3_reg != '0);
    end

    assign stat.busy = v1_reg | v2_reg | v3_reg | v4_reg | hit_reg;
    assign stat.hit  = hit_reg;

endmodule

// ===== hw/rtl/greedy_box_suppression_unit.sv =====
// Top level of the greedy box suppression unit: sequencer, configuration port and result register.
//
//   channel | ports            | direction | beat
//   --------+------------------+-----------+-----------------------------------------
//   input   | s_valid/s_ready  | in        | gbs_in_t: one candidate box
//   result  | m_valid/m_ready  | out       | gbs_out_t: keep, index, count, overflow
//   config  | psel/penable/... | in/out    | iou_threshold at byte address 0
//
// From accept to result a box passes through the area, scan, decide and output states:
// the kept store is read one entry per cycle into the IoU pipeline, which then drains.
// The next box is accepted in the cycle the result appears.
// Reset is synchronous, active low; it clears the counters and loads the threshold with 115.
// The next box is accepted while a finished result still waits in the output register;
// the sequencer holds a new result only while that register is still occupied.
module greedy_box_suppression_unit
    import gbs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  gbs_in_t            s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output gbs_out_t           m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    gbs_state_t        state_reg, state_next;
    gbs_box_t          box_reg, box_next;
    logic [AREA_W-1:0] area_a_reg, area_a_next;
    logic [THR_W-1:0]  thr_reg, thr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  index_reg, index_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              rd_valid_reg, rd_valid_next;
    logic              supp_reg, supp_next;
    gbs_out_t          pend_reg, pend_next;
    logic              m_valid_reg, m_valid_next;
    gbs_out_t          m_data_reg, m_data_next;

    logic              cfg_wr;
    logic              rd_en;
    logic              wr_en;
    logic              survive;
    logic              has_room;
    gbs_box_t          kept_box;
    gbs_iou_stat_t     iou_stat;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[PADDR_W-1:2] == REG_IOU_THR);
    assign prdata = (paddr[PADDR_W-1:2] == REG_IOU_THR)
                    ? {{(PDATA_W-THR_W){1'b0}}, thr_reg} : '0;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign survive  = !supp_reg;
    assign has_room = (count_reg != CNT_W'(MAX_KEPT));
    assign rd_en    = (state_reg == ST_SCAN) && (issue_reg != count_reg);
    assign wr_en    = (state_reg == ST_DECIDE) && survive && has_room;

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        box_next      = box_reg;
        area_a_next   = area_a_reg;
        thr_next      = cfg_wr ? pwdata[THR_W-1:0] : thr_reg;
        count_next    = count_reg;
        index_next    = index_reg;
        issue_next    = issue_reg;
        rd_valid_next = rd_en;
        supp_next     = supp_reg | iou_stat.hit;
        pend_next     = pend_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                // Take a box; a set start clears the count and index first
                if (s_valid) begin
                    box_next.left = s_data.box_x0;
                    box_next.top  = s_data.box_y0;
                    box_next.wide = s_data.box_width;
                    box_next.tall = s_data.box_height;
                    supp_next     = 1'b0;
                    if (s_data.set_start) begin
                        count_next = '0;
                        index_next = '0;
                    end
                    state_next = ST_AREA;
                end
            end
            ST_AREA: begin
                area_a_next = AREA_W'(box_reg.wide) * AREA_W'(box_reg.tall);
                issue_next  = '0;
                state_next  = ST_SCAN;
            end
            ST_SCAN: begin
                // Issue one kept entry per cycle, then wait for the pipeline to drain
                if (rd_en) begin
                    issue_next = issue_reg + CNT_W'(1);
                end else if (!rd_valid_reg && !iou_stat.busy) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                pend_next.keep           = survive && has_room;
                pend_next.store_overflow = survive && !has_room;
                pend_next.item_index     = index_reg;
                if (wr_en) begin
                    count_next = count_reg + CNT_W'(1);
                end
                pend_next.kept_total = wr_en ? (count_reg + CNT_W'(1)) : count_reg;
                index_next = index_reg + IDX_W'(1);
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = pend_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            thr_reg      <= THR_RESET;
            count_reg    <= '0;
            index_reg    <= '0;
            issue_reg    <= '0;
            rd_valid_reg <= 1'b0;
            supp_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            thr_reg      <= thr_next;
            count_reg    <= count_next;
            index_reg    <= index_next;
            issue_reg    <= issue_next;
            rd_valid_reg <= rd_valid_next;
            supp_reg     <= supp_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        box_reg    <= box_next;
        area_a_reg <= area_a_next;
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
    end

    gbs_kept_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[KEPT_AW-1:0]),
        .wr_data (box_reg),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[KEPT_AW-1:0]),
        .rd_data (kept_box)
    );

    gbs_iou_unit u_iou (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rd_valid_reg),
        .kept_box  (kept_box),
        .cand_box  (box_reg),
        .cand_area (area_a_reg),
        .iou_thr   (thr_reg),
        .stat      (iou_stat)
    );

endmodule

// ===== sim/greedy_box_suppression_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the greedy box suppression unit: predicts every result beat and compares it.
module greedy_box_suppression_checker
    import gbs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  gbs_in_t            s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  gbs_out_t           m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output int                 fail_count,
    output int                 verdicts_owed
);

    // Shadow copy of the threshold register, the kept store and the counters
    logic [THR_W-1:0] iou_thr;
    longint           kept_left [MAX_KEPT];
    longint           kept_top  [MAX_KEPT];
    longint           kept_wide [MAX_KEPT];
    longint           kept_tall [MAX_KEPT];
    int               kept_count;
    int               next_index;
    gbs_out_t         predicted_verdicts[$];

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t ns: %s got %0d, want %0d", $time, what, got, want);
        fail_count++;
    endtask

    // Queue one predicted beat behind those already owed
    task automatic owe_verdict(input gbs_out_t v);
        predicted_verdicts.insert(predicted_verdicts.size(), v);
    endtask

    // Length of the overlap of spans [a0, a0+aw) and [b0, b0+bw), zero when apart
    function automatic longint span_overlap(longint a0, longint aw, longint b0, longint bw);
        longint lo;
        longint hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = (a0 + aw < b0 + bw) ? a0 + aw : b0 + bw;
        return (hi > lo) ? hi - lo : 0;
    endfunction

    // Decide one box against every kept box, then update the store and counters
    function automatic gbs_out_t suppress_box(gbs_in_t b);
        longint   x0;
        longint   y0;
        longint   w;
        longint   h;
        longint   inter;
        longint   uni;
        bit       survive;
        gbs_out_t v;
        int       j;
        x0 = $signed(b.box_x0);
        y0 = $signed(b.box_y0);
        w  = b.box_width;
        h  = b.box_height;
        if (b.set_start) begin
            kept_count = 0;
            next_index = 0;
        end
        v = '0;
        v.item_index = 13'(next_index);
        survive = 1'b1;
        for (j = 0; j < kept_count; j++) begin
            inter = span_overlap(x0, w, kept_left[j], kept_wide[j])
                  * span_overlap(y0, h, kept_top[j], kept_tall[j]);
            uni = w * h + kept_wide[j] * kept_tall[j] - inter;
            // a zero union never suppresses
            if (uni != 0 && inter * 256 > longint'(iou_thr) * uni) begin
                survive = 1'b0;
            end
        end
        if (survive && kept_count < MAX_KEPT) begin
            kept_left[kept_count] = x0;
            kept_top[kept_count]  = y0;
            kept_wide[kept_count] = w;
            kept_tall[kept_count] = h;
            kept_count++;
            v.keep = 1'b1;
        end else if (survive) begin
            v.store_overflow = 1'b1;
        end
        next_index = (next_index + 1) % MAX_ITEMS;
        v.kept_total = 7'(kept_count);
        return v;
    endfunction

    // Track register writes, predict on input beats, compare on result beats
    always @(posedge aclk) begin
        gbs_out_t want;
        if (!aresetn) begin
            iou_thr    = THR_RESET;
            kept_count = 0;
            next_index = 0;
            predicted_verdicts.delete();
            verdicts_owed <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_IOU_THR) begin
                iou_thr = pwdata[THR_W-1:0];
            end
            if (m_valid && m_ready) begin
                if (predicted_verdicts.size() == 0) begin
                    report_mismatch("result beat with none owed", longint'(m_data), 0);
                end else begin
                    want = predicted_verdicts.pop_front();
                    if (m_data.keep !== want.keep)
                        report_mismatch("keep", m_data.keep, want.keep);
                    if (m_data.item_index !== want.item_index)
                        report_mismatch("item_index", m_data.item_index, want.item_index);
                    if (m_data.kept_total !== want.kept_total)
                        report_mismatch("kept_total", m_data.kept_total, want.kept_total);
                    if (m_data.store_overflow !== want.store_overflow)
                        report_mismatch("store_overflow", m_data.store_overflow,
                                        want.store_overflow);
                end
            end
            if (s_valid && s_ready) begin
                owe_verdict(suppress_box(s_data));
            end
            verdicts_owed <= predicted_verdicts.size();
        end
    end

endmodule

// ===== sim/greedy_box_suppression_unit_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the greedy box suppression unit: clock, reset, stimulus and verdict.
module greedy_box_suppression_unit_test
    import gbs_pkg::*;
();

    // Longest quiet stretch of a correct run is one full scan plus the end pause;
    // random gaps and stalls lengthen it further, but this limit is still ample.
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 2 * (MAX_KEPT + 9);

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    gbs_in_t            s_data  = '0;
    logic               m_ready = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic               s_ready;
    logic               m_valid;
    gbs_out_t           m_data;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int fail_count;
    int verdicts_owed;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    greedy_box_suppression_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    greedy_box_suppression_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .verdicts_owed (verdicts_owed)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stall the result channel at the current rate
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // End the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic gbs_in_t box_of(int x0, int y0, int w, int h, bit start);
        gbs_in_t b;
        b.box_x0     = 16'(x0);
        b.box_y0     = 16'(y0);
        b.box_width  = 15'(w);
        b.box_height = 15'(h);
        b.set_start  = start;
        return b;
    endfunction

    // Mostly boxes clustered around the set's center, some degenerate, some anything at all
    function automatic gbs_in_t random_box(bit start, int cx, int cy);
        int pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            return box_of($urandom, $urandom, $urandom, $urandom, start);
        end else if (pick < 22) begin
            return box_of(cx + $urandom_range(0, 256) - 128, cy + $urandom_range(0, 256) - 128,
                          (pick < 18) ? 0 : $urandom_range(0, 600),
                          (pick < 18) ? $urandom_range(0, 600) : 0, start);
        end
        return box_of(cx + $urandom_range(0, 400) - 200, cy + $urandom_range(0, 400) - 200,
                      $urandom_range(1, 800), $urandom_range(1, 800), start);
    endfunction

    // Present one beat and hold it until accepted, then maybe idle
    task automatic send_box(input gbs_in_t b);
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Drop valid and wait until every owed result has been taken
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (verdicts_owed != 0);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_IOU_THR, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Send sets of boxes: mostly short, some long enough to fill the store
    task automatic run_sets(input int boxes);
        int left_over;
        int set_len;
        int cx;
        int cy;
        int k;
        left_over = boxes;
        while (left_over > 0) begin
            set_len = ($urandom_range(99) < 15) ? $urandom_range(40, 90) : $urandom_range(1, 24);
            cx = $urandom_range(0, 60000) - 30000;
            cy = $urandom_range(0, 60000) - 30000;
            for (k = 0; k < set_len && left_over > 0; k++) begin
                // now and then a set runs on without its start flag
                send_box(random_box(k == 0 && $urandom_range(9) != 0, cx, cy));
                left_over--;
            end
        end
    endtask

    task automatic run_phase(input int thr, input int send_pct, input int recv_pct,
                             input int boxes);
        settle();
        write_threshold(THR_W'((thr < 0) ? $urandom_range(1, 255) : thr));
        send_idle_pct  = send_pct;
        recv_stall_pct <= recv_pct;
        run_sets(boxes);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed boxes at the reset threshold
        send_box(box_of(0, 0, 160, 160, 1'b1));
        send_box(box_of(0, 0, 160, 160, 1'b0));          // identical: suppressed
        send_box(box_of(80, 0, 160, 160, 1'b0));         // IoU of one third: kept
        send_box(box_of(0, 0, 0, 160, 1'b0));            // zero width
        send_box(box_of(0, 0, 0, 160, 1'b0));            // zero union with the one before
        send_box(box_of(0, 0, 160, 0, 1'b0));            // zero height
        send_box(box_of(-32768, -32768, 32767, 32767, 1'b0));
        send_box(box_of(32767, 32767, 32767, 32767, 1'b0));
        send_box(box_of(32767, 32767, 32767, 32767, 1'b0));
        send_box(box_of(-1, -1, 1, 1, 1'b0));
        send_box(box_of(0, 0, 160, 160, 1'b1));          // new set mid-stream
        send_box(box_of(160, 0, 160, 160, 1'b0));        // touching edges
        send_box(box_of(0, 0, 80, 80, 1'b0));            // nested
        send_box(box_of(1000, 0, 256, 1, 1'b0));
        send_box(box_of(1000, 0, 115, 1, 1'b0));         // IoU exactly at the limit
        send_box(box_of(1000, 0, 116, 1, 1'b0));         // just above the limit

        // Random sets over thresholds and idling patterns
        run_phase(115, 0, 0, 250);
        run_phase(0, 68, 0, 200);
        run_phase(511, 0, 68, 200);
        run_phase(256, 24, 24, 200);
        run_phase(200, 0, 0, 200);
        run_phase(-1, 68, 0, 200);
        run_phase(1, 0, 68, 150);
        run_phase(-1, 24, 24, 200);

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/gbs_pkg.sv
hw/rtl/gbs_kept_store.sv
hw/rtl/gbs_iou_unit.sv
hw/rtl/greedy_box_suppression_unit.sv
sim/greedy_box_suppression_checker.sv
sim/greedy_box_suppression_unit_test.sv
